// File: design/lissajous_curve_generator_top_defines.svh
// Assertion macros shared by the Lissajous curve generator RTL.
`ifndef LISSAJOUS_CURVE_GENERATOR_TOP_DEFINES_SVH
`define LISSAJOUS_CURVE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LCG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/lcg_pkg.sv
// Types, constants and helper functions shared by the Lissajous curve generator.
`default_nettype none

package lcg_pkg;

   // Fixed field widths.
   localparam int TIME_STEP_W  = 16;
   localparam int AMP_W        = 16;
   localparam int FREQ_W       = 24;
   localparam int ANGLE_W      = 16;
   localparam int SPEED_W      = 16;
   localparam int POS_W        = 17;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   // CORDIC datapath widths: Q2.30 vector, angle in 2^-32 turn.
   localparam int CORDIC_W     = 34;
   localparam int Z_W          = 32;
   localparam int ATAN_W       = 30;
   localparam int ATAN_IDX_W   = 5;
   localparam int Q15_W        = 16;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032875;
   localparam logic [SPEED_W-1:0] TIME_SPEED_RESET    = 16'd256;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_AMPLITUDE    = 3'd0,
      CSR_Y_AMPLITUDE    = 3'd1,
      CSR_X_FREQUENCY    = 3'd2,
      CSR_Y_FREQUENCY    = 3'd3,
      CSR_X_PHASE_OFFSET = 3'd4,
      CSR_TIME_SPEED     = 3'd5
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DT,
      ST_FX,
      ST_FY,
      ST_ADDY,
      ST_ROT,
      ST_WAIT,
      ST_SX,
      ST_SY,
      ST_OUT
   } lcg_state_type;

   // Request to the rotation unit.
   typedef struct packed {
      logic                start;
      logic [ANGLE_W-1:0]  angle_x;
      logic [ANGLE_W-1:0]  angle_y;
   } rot_req_type;

   // Status from the rotation unit; sin_x and cos_y are signed Q1.15.
   typedef struct packed {
      logic                done;
      logic [Q15_W-1:0]    sin_x;
      logic [Q15_W-1:0]    cos_y;
   } rot_rsp_type;

   // Arctangent of 2^-i in 2^-32 turn.
   function automatic logic [ATAN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      unique case (idx)
         5'd0:  val = 30'd536870912;
         5'd1:  val = 30'd316933406;
         5'd2:  val = 30'd167458907;
         5'd3:  val = 30'd85004756;
         5'd4:  val = 30'd42667331;
         5'd5:  val = 30'd21354465;
         5'd6:  val = 30'd10679838;
         5'd7:  val = 30'd5340245;
         5'd8:  val = 30'd2670163;
         5'd9:  val = 30'd1335087;
         5'd10: val = 30'd667544;
         5'd11: val = 30'd333772;
         5'd12: val = 30'd166886;
         5'd13: val = 30'd83443;
         5'd14: val = 30'd41722;
         5'd15: val = 30'd20861;
         5'd16: val = 30'd10430;
         5'd17: val = 30'd5215;
         5'd18: val = 30'd2608;
         5'd19: val = 30'd1304;
         5'd20: val = 30'd652;
         5'd21: val = 30'd326;
         5'd22: val = 30'd163;
         5'd23: val = 30'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Round a Q2.30 value half up to Q1.15 and saturate to +/-32767.
   function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] biased;
      logic signed [18:0]         r;
      logic signed [Q15_W-1:0]    res;
      biased = v + 34'sd16384;
      r      = 19'(biased >>> 15);
      if (r > 19'sd32767) begin
         res = 16'sd32767;
      end else if (r < -19'sd32767) begin
         res = -16'sd32767;
      end else begin
         res = 16'(r);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: design/lissajous_curve_generator_top.sv
// One request at a time: a new request is taken only in idle, after the last point reaches the
// output register; the pace is set by the iterative CORDIC rotation and the single shared
// multiplier that the sequencer uses five times per request.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears both phases, the sequencer and the output valid;
// registers return to zero except time_speed, which returns to 1.0 (256).
`default_nettype none

module lissajous_curve_generator_top #(
   parameter int PHASE_BITS     = 32,
   parameter int CORDIC_STEPS   = 16,
   parameter int AMPLITUDE_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] time_step
   input  wire         req_tuser,   // [0] restart
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] pos_x, [33:17] pos_y, [39:34] zero
   // Configuration write port.
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [23:0] csr_wdata
);

   `include "lissajous_curve_generator_top_defines.svh"

   localparam int AMP_KEEP = (AMPLITUDE_BITS < lcg_pkg::AMP_W) ? AMPLITUDE_BITS : lcg_pkg::AMP_W;
   localparam logic [lcg_pkg::AMP_W-1:0] AMP_MASK =
      lcg_pkg::AMP_W'((17'd1 << AMP_KEEP) - 17'd1);
   localparam int PROD_W = 58;
   localparam int WIDE_W = 56 + PHASE_BITS;

   // Configuration registers.
   logic [lcg_pkg::AMP_W-1:0]   x_amp_ff, y_amp_ff;
   logic [lcg_pkg::FREQ_W-1:0]  x_freq_ff, y_freq_ff;
   logic [lcg_pkg::ANGLE_W-1:0] x_offset_ff;
   logic [lcg_pkg::SPEED_W-1:0] speed_ff;

   // Sequencer and datapath.
   lcg_pkg::lcg_state_type state_ff, state_in;
   logic [lcg_pkg::TIME_STEP_W-1:0] step_ff;
   logic [31:0]                     dt_ff;
   logic [PHASE_BITS-1:0]           x_phase_ff, y_phase_ff, phase_inc;
   logic [WIDE_W-1:0]               prod_wide;
   logic signed [32:0]              mul_a;
   logic signed [24:0]              mul_b;
   logic                            mul_en;
   logic signed [PROD_W-1:0]        prod_ff, prod_rnd;
   logic [lcg_pkg::POS_W-1:0]       pos_x_ff;
   logic                            rsp_tvalid_ff;
   logic [2*lcg_pkg::POS_W-1:0]     rsp_data_ff;
   logic                            out_free;
   logic                            rot_start;
   lcg_pkg::rot_req_type            rot_req;
   lcg_pkg::rot_rsp_type            rot_rsp;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_amp_ff    <= '0;
         y_amp_ff    <= '0;
         x_freq_ff   <= '0;
         y_freq_ff   <= '0;
         x_offset_ff <= '0;
         speed_ff    <= lcg_pkg::TIME_SPEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lcg_pkg::CSR_X_AMPLITUDE:    x_amp_ff    <= csr_wdata[15:0];
            lcg_pkg::CSR_Y_AMPLITUDE:    y_amp_ff    <= csr_wdata[15:0];
            lcg_pkg::CSR_X_FREQUENCY:    x_freq_ff   <= csr_wdata;
            lcg_pkg::CSR_Y_FREQUENCY:    y_freq_ff   <= csr_wdata;
            lcg_pkg::CSR_X_PHASE_OFFSET: x_offset_ff <= csr_wdata[15:0];
            lcg_pkg::CSR_TIME_SPEED:     speed_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcg_pkg::ST_IDLE: if (req_tvalid) state_in = lcg_pkg::ST_DT;
         lcg_pkg::ST_DT:   state_in = lcg_pkg::ST_FX;
         lcg_pkg::ST_FX:   state_in = lcg_pkg::ST_FY;
         lcg_pkg::ST_FY:   state_in = lcg_pkg::ST_ADDY;
         lcg_pkg::ST_ADDY: state_in = lcg_pkg::ST_ROT;
         lcg_pkg::ST_ROT:  state_in = lcg_pkg::ST_WAIT;
         lcg_pkg::ST_WAIT: if (rot_rsp.done) state_in = lcg_pkg::ST_SX;
         lcg_pkg::ST_SX:   state_in = lcg_pkg::ST_SY;
         lcg_pkg::ST_SY:   state_in = lcg_pkg::ST_OUT;
         lcg_pkg::ST_OUT:  if (out_free) state_in = lcg_pkg::ST_IDLE;
         default:          state_in = lcg_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, rotation start and shared multiplier operands.
   always_comb begin
      req_tready = 1'b0;
      rot_start  = 1'b0;
      mul_en     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         lcg_pkg::ST_IDLE: req_tready = 1'b1;
         lcg_pkg::ST_DT: begin
            mul_en = 1'b1;
            mul_a  = $signed({17'b0, step_ff});
            mul_b  = $signed({9'b0, speed_ff});
         end
         lcg_pkg::ST_FX: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, prod_ff[31:0]});
            mul_b  = $signed({1'b0, x_freq_ff});
         end
         lcg_pkg::ST_FY: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, dt_ff});
            mul_b  = $signed({1'b0, y_freq_ff});
         end
         lcg_pkg::ST_ROT: rot_start = 1'b1;
         lcg_pkg::ST_SX: begin
            mul_en = 1'b1;
            mul_a  = 33'($signed(rot_rsp.sin_x));
            mul_b  = $signed({9'b0, x_amp_ff & AMP_MASK});
         end
         lcg_pkg::ST_SY: begin
            mul_en = 1'b1;
            mul_a  = 33'($signed(rot_rsp.cos_y));
            mul_b  = $signed({9'b0, y_amp_ff & AMP_MASK});
         end
         default: ;
      endcase
   end

   // Phase increment: bits [39 : 40 - PHASE_BITS] of the Q16.40 product, zero-filled below.
   assign prod_wide = {prod_ff[55:0], {PHASE_BITS{1'b0}}};
   assign phase_inc = prod_wide[40 + PHASE_BITS - 1 : 40];

   // Rotation request; the angles come from the top 16 phase bits.
   assign rot_req = '{
      start:   rot_start,
      angle_x: x_phase_ff[PHASE_BITS-1 -: lcg_pkg::ANGLE_W] + x_offset_ff,
      angle_y: y_phase_ff[PHASE_BITS-1 -: lcg_pkg::ANGLE_W]
   };

   // Amplitude product rounded half up by a shift of 15.
   assign prod_rnd = prod_ff + 58'sd16384;

   lcg_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .req  (rot_req),
      .rsp  (rot_rsp)
   );

   // State, phases and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lcg_pkg::ST_IDLE;
         x_phase_ff    <= '0;
         y_phase_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_tvalid && req_tready && req_tuser) begin
            x_phase_ff <= '0;
            y_phase_ff <= '0;
         end
         if (state_ff == lcg_pkg::ST_FY) begin
            x_phase_ff <= x_phase_ff + phase_inc;
         end
         if (state_ff == lcg_pkg::ST_ADDY) begin
            y_phase_ff <= y_phase_ff + phase_inc;
         end
         if (state_ff == lcg_pkg::ST_OUT && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         step_ff <= req_tdata;
      end
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (state_ff == lcg_pkg::ST_FX) begin
         dt_ff <= prod_ff[31:0];
      end
      if (state_ff == lcg_pkg::ST_SY) begin
         pos_x_ff <= prod_rnd[31:15];
      end
      if (state_ff == lcg_pkg::ST_OUT && out_free) begin
         rsp_data_ff <= {prod_rnd[31:15], pos_x_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

   // An accepted request always starts with the time scaling step.
   `LCG_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready,
      state_ff == lcg_pkg::ST_DT, "accepted request did not start the sequence")
   // The rotation unit finishes only while the sequencer waits for it.
   `LCG_ASSERT_NOW(a_done_in_wait, clock, reset, rot_rsp.done,
      state_ff == lcg_pkg::ST_WAIT, "rotation finished outside the wait state")
   // A finished point moves to the output register and frees the block.
   `LCG_ASSERT_NEXT(a_out_loads, clock, reset, state_ff == lcg_pkg::ST_OUT && out_free,
      rsp_tvalid && state_ff == lcg_pkg::ST_IDLE, "finished point was not presented")

endmodule

`default_nettype wire

// File: design/lcg_cordic.sv
// Two-lane iterative rotation-mode CORDIC giving sine of the x angle and cosine of the y angle.
`default_nettype none

module lcg_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  lcg_pkg::rot_req_type req,
   output lcg_pkg::rot_rsp_type rsp
);

   localparam int ITER_W = $clog2(CORDIC_STEPS);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

   // Iteration control.
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [lcg_pkg::ATAN_IDX_W-1:0] atan_idx;
   logic signed [lcg_pkg::Z_W-1:0] atan_z;

   // Per-lane vector, residual angle and quadrant; lane 0 is x, lane 1 is y.
   logic signed [lcg_pkg::CORDIC_W-1:0] x_ff[2], x_in[2];
   logic signed [lcg_pkg::CORDIC_W-1:0] y_ff[2], y_in[2];
   logic signed [lcg_pkg::CORDIC_W-1:0] xs[2], ys[2];
   logic signed [lcg_pkg::Z_W-1:0]      z_ff[2], z_in[2];
   logic [1:0]                          quad_ff[2], quad_in[2];
   logic [lcg_pkg::ANGLE_W-1:0]         angle[2];
   logic signed [lcg_pkg::Q15_W-1:0]    cos_r[2], sin_r[2];
   logic signed [lcg_pkg::Q15_W-1:0]    sin_x, cos_y;

   assign angle[0] = req.angle_x;
   assign angle[1] = req.angle_y;
   assign atan_idx = lcg_pkg::ATAN_IDX_W'(iter_ff);
   assign atan_z   = $signed({2'b00, lcg_pkg::atan_turn(atan_idx)});

   // Counter: runs CORDIC_STEPS iterations after a start, then pulses done.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      if (req.start) begin
         busy_in = 1'b1;
         iter_in = '0;
      end else if (busy_ff) begin
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // One micro-rotation per lane and cycle while busy.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         xs[l]      = x_ff[l] >>> iter_ff;
         ys[l]      = y_ff[l] >>> iter_ff;
         x_in[l]    = x_ff[l];
         y_in[l]    = y_ff[l];
         z_in[l]    = z_ff[l];
         quad_in[l] = quad_ff[l];
         if (req.start) begin
            x_in[l]    = lcg_pkg::CORDIC_GAIN;
            y_in[l]    = '0;
            z_in[l]    = $signed({2'b00, angle[l][13:0], 16'b0});
            quad_in[l] = angle[l][15:14];
         end else if (busy_ff) begin
            if (!z_ff[l][lcg_pkg::Z_W-1]) begin
               x_in[l] = x_ff[l] - ys[l];
               y_in[l] = y_ff[l] + xs[l];
               z_in[l] = z_ff[l] - atan_z;
            end else begin
               x_in[l] = x_ff[l] + ys[l];
               y_in[l] = y_ff[l] - xs[l];
               z_in[l] = z_ff[l] + atan_z;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      for (int l = 0; l < 2; l++) begin
         x_ff[l]    <= x_in[l];
         y_ff[l]    <= y_in[l];
         z_ff[l]    <= z_in[l];
         quad_ff[l] <= quad_in[l];
      end
   end

   // Round each lane to Q1.15.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         cos_r[l] = lcg_pkg::to_q15(x_ff[l]);
         sin_r[l] = lcg_pkg::to_q15(y_ff[l]);
      end
   end

   // Fold the quadrant back in: sine for x, cosine for y.
   always_comb begin
      unique case (quad_ff[0])
         2'd0:    sin_x = sin_r[0];
         2'd1:    sin_x = cos_r[0];
         2'd2:    sin_x = -sin_r[0];
         default: sin_x = -cos_r[0];
      endcase
      unique case (quad_ff[1])
         2'd0:    cos_y = cos_r[1];
         2'd1:    cos_y = -sin_r[1];
         2'd2:    cos_y = -cos_r[1];
         default: cos_y = sin_r[1];
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.sin_x = sin_x;
   assign rsp.cos_y = cos_y;

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the Lissajous curve generator: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module tb_top;

   // Block configuration mirrored by the predictor.
   localparam int CORDIC_STEPS = 16;
   localparam longint ROT_GAIN = 64'sd652032875;
   localparam longint ATAN_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };
   // Register indexes past the end of the register list.
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      bit [15:0] step;
      bit        restart;
   } request_type;

   typedef struct packed {
      bit [16:0] pos_x;
      bit [16:0] pos_y;
   } point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] time_step
   logic        req_tuser = 1'b0; // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [16:0] pos_x, [33:17] pos_y, [39:34] zero
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // Predictor copy of the registers and the two phase accumulators.
   bit [15:0] amp_x_q, amp_y_q, offset_x_q, speed_q;
   bit [23:0] freq_x_q, freq_y_q;
   bit [31:0] phase_x_q, phase_y_q;

   request_type pending_steps[$];
   point_type   expected_points[$];
   request_type cur_req;
   bit [31:0] cycle_count = '0;
   int        mismatches = 0;
   int        requests_sent = 0;
   int        points_seen = 0;
   int        settings_used = 0;
   int        hold_left = 0;

   // Stretches with no random idling on either side.
   wire calm = (cycle_count[13:11] == 3'd3);

   lissajous_curve_generator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Phase increment: Q8.24 time times Q8.16 rate, kept to 32 fraction bits of a turn.
   function automatic bit [31:0] phase_advance(bit [31:0] dt, bit [23:0] freq);
      bit [63:0] prod;
      prod = 64'(dt) * 64'(freq);
      return prod[39:8];
   endfunction

   // Round a Q2.30 value half up to Q1.15 and clamp to +/-32767.
   function automatic longint round_q15(longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32767) begin
         r = -32767;
      end
      return r;
   endfunction

   // Sine and cosine of an angle in 1/65536 turn, by quadrant plus rotation.
   function automatic void rotate_angle(bit [15:0] angle, output longint sin_q,
                                        output longint cos_q);
      longint vx, vy, vz, sx, sy, sr, cr;
      vx = ROT_GAIN;
      vy = 0;
      vz = longint'(angle[13:0]) << 16;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (vz >= 0) begin
            vx = vx - sy;
            vy = vy + sx;
            vz = vz - ATAN_TURNS[i];
         end else begin
            vx = vx + sy;
            vy = vy - sx;
            vz = vz + ATAN_TURNS[i];
         end
      end
      cr = round_q15(vx);
      sr = round_q15(vy);
      case (angle[15:14])
         2'd0: begin sin_q = sr;  cos_q = cr;  end
         2'd1: begin sin_q = cr;  cos_q = -sr; end
         2'd2: begin sin_q = -sr; cos_q = -cr; end
         default: begin sin_q = -cr; cos_q = sr; end
      endcase
   endfunction

   // Amplitude times a Q1.15 value, rounded half up, as a 17-bit field.
   function automatic bit [16:0] scale_axis(bit [15:0] amp, longint q15);
      longint r;
      r = (longint'(amp) * q15 + 64'sd16384) >>> 15;
      return r[16:0];
   endfunction

   // Advance the curve time by one request and compute the point it lands on.
   function automatic point_type advance_curve(request_type r);
      bit [31:0] dt;
      bit [15:0] angle_x, angle_y;
      longint    sin_x, cos_x, sin_y, cos_y;
      point_type pt;
      dt = 32'(r.step) * 32'(speed_q);
      if (r.restart) begin
         phase_x_q = '0;
         phase_y_q = '0;
      end
      phase_x_q = phase_x_q + phase_advance(dt, freq_x_q);
      phase_y_q = phase_y_q + phase_advance(dt, freq_y_q);
      angle_x = phase_x_q[31:16] + offset_x_q;
      angle_y = phase_y_q[31:16];
      rotate_angle(angle_x, sin_x, cos_x);
      rotate_angle(angle_y, sin_y, cos_y);
      pt.pos_x = scale_axis(amp_x_q, sin_x);
      pt.pos_y = scale_axis(amp_y_q, cos_y);
      return pt;
   endfunction

   // Request driver: predicts on acceptance, then offers the next pending request.
   always @(posedge clock) begin : driver
      request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_points.push_back(advance_curve(cur_req));
            requests_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_steps.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
               nxt = pending_steps.pop_front();
               cur_req = nxt;
               req_tvalid <= 1'b1;
               req_tdata <= nxt.step;
               req_tuser <= nxt.restart;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off: long stretches with rsp_tready low while requests keep coming.
   always @(posedge clock) begin : stall_gen
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (cycle_count == 32'd5000 || cycle_count == 32'd30000) begin
         hold_left <= 300;
      end
   end

   // Result monitor: compares each point with the oldest prediction and paces rsp_tready.
   always @(posedge clock) begin : monitor
      point_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: point %h arrived with no request outstanding", rsp_tdata);
               end
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata[16:0] !== want.pos_x || rsp_tdata[33:17] !== want.pos_y ||
                   rsp_tdata[39:34] !== 6'd0) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: point %0d expected x=%0d y=%0d pad=0,",
                              points_seen, $signed(want.pos_x), $signed(want.pos_y));
                     $display("       got x=%0d y=%0d pad=%h",
                              $signed(rsp_tdata[16:0]), $signed(rsp_tdata[33:17]),
                              rsp_tdata[39:34]);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 17);
         end
      end
   end

   // Register write while the block is idle; the predictor follows at once.
   task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      if (idx == lcg_pkg::CSR_X_FREQUENCY || idx == lcg_pkg::CSR_Y_FREQUENCY) begin
         csr_wdata <= value;
      end else begin
         csr_wdata <= {8'($urandom), value[15:0]};
      end
      case (idx)
         lcg_pkg::CSR_X_AMPLITUDE:    amp_x_q = value[15:0];
         lcg_pkg::CSR_Y_AMPLITUDE:    amp_y_q = value[15:0];
         lcg_pkg::CSR_X_FREQUENCY:    freq_x_q = value;
         lcg_pkg::CSR_Y_FREQUENCY:    freq_y_q = value;
         lcg_pkg::CSR_X_PHASE_OFFSET: offset_x_q = value[15:0];
         lcg_pkg::CSR_TIME_SPEED:     speed_q = value[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_step(input bit [15:0] step, input bit restart);
      request_type r;
      r.step = step;
      r.restart = restart;
      pending_steps.push_back(r);
   endtask

   // Wait until every queued request has been taken and answered.
   task automatic drain();
      @(negedge clock);
      while (pending_steps.size() != 0 || req_tvalid || expected_points.size() != 0) begin
         @(negedge clock);
      end
      settings_used++;
   endtask

   // Register value: often an extreme, otherwise small or fully random.
   function automatic bit [23:0] pick_setting(int width);
      bit [23:0] top;
      top = 24'((64'd1 << width) - 1);
      case ($urandom_range(5))
         0: return '0;
         1: return top;
         2: return 24'($urandom_range(255));
         default: return 24'($urandom) & top;
      endcase
   endfunction

   // Stimulus sequence: directed settings first, then randomized phases.
   initial begin
      bit [15:0] step;
      amp_x_q = '0;
      amp_y_q = '0;
      freq_x_q = '0;
      freq_y_q = '0;
      offset_x_q = '0;
      speed_q = 16'd256;
      phase_x_q = '0;
      phase_y_q = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Registers at their reset values.
      queue_step(16'hFFFF, 1'b0);
      queue_step(16'h1234, 1'b1);
      drain();

      // Full-scale amplitudes, unit x rate, double y rate, speed left at reset.
      write_reg(lcg_pkg::CSR_X_AMPLITUDE, 24'h00FFFF);
      write_reg(lcg_pkg::CSR_Y_AMPLITUDE, 24'h00FFFF);
      write_reg(lcg_pkg::CSR_X_FREQUENCY, 24'h010000);
      write_reg(lcg_pkg::CSR_Y_FREQUENCY, 24'h020000);
      queue_step(16'h0000, 1'b1);
      queue_step(16'h4000, 1'b0);
      queue_step(16'h4000, 1'b0);
      queue_step(16'h4000, 1'b0);
      queue_step(16'h4000, 1'b0);
      queue_step(16'h2000, 1'b0);
      queue_step(16'hFFFF, 1'b0);
      queue_step(16'h0001, 1'b0);
      queue_step(16'h0000, 1'b0);
      queue_step(16'h8000, 1'b1);
      queue_step(16'h1555, 1'b0);
      drain();

      // Quarter-turn x offset.
      write_reg(lcg_pkg::CSR_X_PHASE_OFFSET, 24'h004000);
      queue_step(16'h0000, 1'b1);
      queue_step(16'h3000, 1'b0);
      queue_step(16'hC000, 1'b0);
      drain();

      // Zero speed: phases must hold while points are recomputed.
      write_reg(lcg_pkg::CSR_TIME_SPEED, 24'h000000);
      queue_step(16'hFFFF, 1'b0);
      queue_step(16'h5A5A, 1'b0);
      queue_step(16'hA5A5, 1'b0);
      drain();

      // Every register but x amplitude (set to 1) at its maximum, writes to unused indexes, then zero amplitude.
      write_reg(lcg_pkg::CSR_TIME_SPEED, 24'h00FFFF);
      write_reg(lcg_pkg::CSR_X_FREQUENCY, 24'hFFFFFF);
      write_reg(lcg_pkg::CSR_Y_FREQUENCY, 24'hFFFFFF);
      write_reg(lcg_pkg::CSR_X_PHASE_OFFSET, 24'h00FFFF);
      write_reg(lcg_pkg::CSR_X_AMPLITUDE, 24'h000001);
      write_reg(CSR_SPARE_LO, 24'($urandom));
      write_reg(CSR_SPARE_HI, 24'hFFFFFF);
      queue_step(16'hFFFF, 1'b0);
      queue_step(16'hFFFF, 1'b0);
      queue_step(16'h7FFF, 1'b1);
      drain();
      write_reg(lcg_pkg::CSR_X_AMPLITUDE, 24'h000000);
      write_reg(lcg_pkg::CSR_Y_AMPLITUDE, 24'h000000);
      queue_step(16'hFFFF, 1'b0);
      queue_step(16'h0001, 1'b1);
      drain();

      // Random settings, each followed by a run of random steps.
      for (int p = 0; p < 8; p++) begin
         write_reg(lcg_pkg::CSR_X_AMPLITUDE, pick_setting(16));
         write_reg(lcg_pkg::CSR_Y_AMPLITUDE, pick_setting(16));
         write_reg(lcg_pkg::CSR_X_FREQUENCY, pick_setting(24));
         write_reg(lcg_pkg::CSR_Y_FREQUENCY, pick_setting(24));
         write_reg(lcg_pkg::CSR_X_PHASE_OFFSET, pick_setting(16));
         if ($urandom_range(1) == 0) begin
            write_reg(lcg_pkg::CSR_TIME_SPEED, 24'($urandom_range(128, 512)));
         end else begin
            write_reg(lcg_pkg::CSR_TIME_SPEED, pick_setting(16));
         end
         if ($urandom_range(2) == 0) begin
            write_reg($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, 24'($urandom));
         end
         for (int k = 0; k < 225; k++) begin
            case ($urandom_range(7))
               0: step = 16'h0000;
               1: step = 16'hFFFF;
               2, 3: step = 16'($urandom_range(255));
               default: step = 16'($urandom);
            endcase
            queue_step(step, $urandom_range(15) == 0);
         end
         drain();
      end

      repeat (40) @(posedge clock);
      $display("Run covered %0d requests and %0d points over %0d register settings,",
               requests_sent, points_seen, settings_used);
      $display("including zero and full-scale settings, restarts and output back-pressure.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("ERROR: run timed out with %0d points outstanding", expected_points.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
